// ===== design/sbbt_pkg.sv =====
// package for the strided byte block transform
// holds sizes, command, operation, scramble and status codes, and the memory write port type
// no dependencies
package sbbt_pkg;

    localparam int MAX_LEN = 4096;
    localparam int ADDR_W  = $clog2(MAX_LEN);
    localparam int LEN_W   = ADDR_W + 1;

    localparam logic [1:0] CMD_LOAD   = 2'd0;
    localparam logic [1:0] CMD_READ   = 2'd1;
    localparam logic [1:0] CMD_APPLY  = 2'd2;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam logic [3:0] OP_XOR      = 4'd0;
    localparam logic [3:0] OP_ADD      = 4'd1;
    localparam logic [3:0] OP_MUL      = 4'd2;
    localparam logic [3:0] OP_CLO_XOR  = 4'd3;
    localparam logic [3:0] OP_NIB_ADD  = 4'd4;
    localparam logic [3:0] OP_CHI_XOR  = 4'd5;
    localparam logic [3:0] OP_CLO_ADD  = 4'd6;
    localparam logic [3:0] OP_CHI_ADD  = 4'd7;
    localparam logic [3:0] OP_NIB_XOR  = 4'd8;
    localparam logic [3:0] OP_NIB_SWAP = 4'd9;
    localparam logic [3:0] OP_AFFINE   = 4'd10;
    localparam logic [3:0] OP_DUAL_XOR = 4'd11;
    localparam logic [3:0] OP_DUAL_ADD = 4'd12;
    localparam logic [3:0] OP_DUAL_MUL = 4'd13;
    localparam logic [3:0] OP_DELTA    = 4'd14;
    localparam logic [3:0] OP_SCRAMBLE = 4'd15;

    localparam logic [3:0] KIND_IL_MAX = 4'd5;
    localparam logic [3:0] KIND_BITS   = 4'd6;
    localparam logic [3:0] KIND_NIBBLE = 4'd7;
    localparam logic [3:0] KIND_REV    = 4'd8;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_REFUSE = 2'd1;
    localparam logic [1:0] ST_RANGE  = 2'd2;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
    } mem_wr_t;

endpackage

// ===== design/sbbt_ram.sv =====
// single write port, single read port byte memory with registered read data
// depends on sbbt_pkg
module sbbt_ram (
    input  logic                       clk,
    input  sbbt_pkg::mem_wr_t          wr,
    input  logic [sbbt_pkg::ADDR_W-1:0] raddr,
    output logic [7:0]                 rdata
);
    import sbbt_pkg::*;

    logic [7:0] mem [MAX_LEN];

    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            mem[wr.addr] <= wr.data;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== design/sbbt_alu.sv =====
// per-byte operation unit for strided instructions
// depends on sbbt_pkg
module sbbt_alu (
    input  logic [3:0]  op,
    input  logic [7:0]  din,
    input  logic [15:0] amp,
    input  logic        odd,
    output logic [7:0]  dout
);
    import sbbt_pkg::*;

    logic [3:0]  lo, hi, a0, a1;
    logic [7:0]  mul_op;
    logic [15:0] prod;
    logic [7:0]  m_lo, m_hi;

    assign lo   = din[3:0];
    assign hi   = din[7:4];
    assign a0   = amp[3:0];
    assign a1   = amp[7:4];
    assign m_lo = {amp[6:0], 1'b0} + 8'd3;
    assign m_hi = {amp[13:7], 1'b0} + 8'd3;

    always_comb
    begin
        unique case (op)
            OP_MUL:      mul_op = amp[7:0];
            OP_DUAL_MUL: mul_op = odd ? m_hi : m_lo;
            default:     mul_op = m_lo;
        endcase
    end

    assign prod = {8'd0, din} * {8'd0, mul_op};

    always_comb
    begin
        unique case (op)
            OP_XOR:      dout = din ^ amp[7:0];
            OP_ADD:      dout = din + amp[7:0];
            OP_MUL:      dout = prod[7:0];
            OP_CLO_XOR:  dout = (hi == a1) ? (din ^ {4'd0, a0}) : din;
            OP_NIB_ADD:  dout = {hi + a1, lo + a0};
            OP_CHI_XOR:  dout = (lo == a0) ? (din ^ {a1, 4'd0}) : din;
            OP_CLO_ADD:  dout = (hi == a1) ? {hi, lo + a0} : din;
            OP_CHI_ADD:  dout = (lo == a0) ? {hi + a1, lo} : din;
            OP_NIB_XOR:  dout = din ^ amp[7:0];
            OP_NIB_SWAP: dout = {lo, hi};
            OP_AFFINE:   dout = prod[7:0] + amp[14:7];
            OP_DUAL_XOR: dout = din ^ (odd ? amp[15:8] : amp[7:0]);
            OP_DUAL_ADD: dout = din + (odd ? amp[15:8] : amp[7:0]);
            default:     dout = prod[7:0];
        endcase
    end

endmodule

// ===== design/strided_byte_block_transform.sv =====
// top level of the strided byte block transform: command sequencer over two byte memories
// depends on sbbt_pkg, sbbt_ram, sbbt_alu
//
// channel  signals                                              direction
// cfg      cfg_valid, cfg_ready, block_len                      in
// in       in_valid, in_ready, cmd, index, value, op_type,
//          step_stride, start_phase, operand_amp                in
// out      out_valid, out_ready, read_value, status             out
//
// load: result in the cycle after accept; read: registered block memory data, then S_RD loads the result
// strided ops: S_ST_RD then S_ST_WR per touched byte; delta xor: S_DX_RD0, S_DX_RD1, S_DX_WR per byte
// scramble: bytes are permuted into scratch memory, then copied back through S_CP_RD and S_CP_WR
// one item at a time: input is taken only when idle and the result register is empty
// reset restores block_len to 4096; memory contents are undefined until loaded
module strided_byte_block_transform (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [sbbt_pkg::LEN_W-1:0] block_len,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [1:0]                 cmd,
    input  logic [11:0]                index,
    input  logic [7:0]                 value,
    input  logic [3:0]                 op_type,
    input  logic [6:0]                 step_stride,
    input  logic [5:0]                 start_phase,
    input  logic [15:0]                operand_amp,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [7:0]                 read_value,
    output logic [1:0]                 status
);
    import sbbt_pkg::*;

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_RD     = 5'd1;
    localparam logic [4:0] S_START  = 5'd2;
    localparam logic [4:0] S_ST_RD  = 5'd3;
    localparam logic [4:0] S_ST_WR  = 5'd4;
    localparam logic [4:0] S_DX_RD0 = 5'd5;
    localparam logic [4:0] S_DX_RD1 = 5'd6;
    localparam logic [4:0] S_DX_WR  = 5'd7;
    localparam logic [4:0] S_IL_RD  = 5'd8;
    localparam logic [4:0] S_IL_WR  = 5'd9;
    localparam logic [4:0] S_BP_RD  = 5'd10;
    localparam logic [4:0] S_BP_CAP = 5'd11;
    localparam logic [4:0] S_BP_WR  = 5'd12;
    localparam logic [4:0] S_NP_RD0 = 5'd13;
    localparam logic [4:0] S_NP_RD1 = 5'd14;
    localparam logic [4:0] S_NP_WR0 = 5'd15;
    localparam logic [4:0] S_NP_WR1 = 5'd16;
    localparam logic [4:0] S_RV_RD  = 5'd17;
    localparam logic [4:0] S_RV_WR  = 5'd18;
    localparam logic [4:0] S_FD_RD0 = 5'd19;
    localparam logic [4:0] S_FD_RD1 = 5'd20;
    localparam logic [4:0] S_FD_WR0 = 5'd21;
    localparam logic [4:0] S_FD_WR1 = 5'd22;
    localparam logic [4:0] S_CP_RD  = 5'd23;
    localparam logic [4:0] S_CP_WR  = 5'd24;

    logic [4:0]       state_reg, state_next;
    logic [LEN_W-1:0] blen_reg;
    logic             out_valid_reg, out_valid_next;
    logic [7:0]       rv_reg, rv_next;
    logic [1:0]       st_reg, st_next;

    logic [3:0]       op_reg, op_next;
    logic [15:0]      amp_reg, amp_next;
    logic [6:0]       stride_reg, stride_next;
    logic [LEN_W-1:0] n_reg, n_next;
    logic [LEN_W-1:0] ptr_reg, ptr_next;
    logic [LEN_W-1:0] cnt_reg, cnt_next;
    logic [LEN_W-1:0] base_reg, base_next;
    logic [LEN_W-1:0] q_reg, q_next;
    logic [LEN_W-1:0] dst_reg, dst_next;
    logic [2:0]       sub_reg, sub_next;
    logic             k_reg, k_next;
    logic [7:0]       hold_reg, hold_next;
    logic [7:0]       hold2_reg, hold2_next;
    logic [7:0][7:0]  gather_reg, gather_next;

    mem_wr_t          b_wr, s_wr;
    logic [ADDR_W-1:0] b_raddr, s_raddr;
    logic [7:0]       b_rdata, s_rdata;
    logic [7:0]       alu_out;

    logic [LEN_W-1:0] n_eff;
    logic             in_fire;
    logic             in_rng;
    logic [3:0]       kind;
    logic [6:0]       il_s;
    logic [LEN_W-1:0] il_w, ps, half;
    logic [LEN_W-1:0] ptr_p1, ptr_m1, ptr_str, cnt_p1;
    logic [7:0]       bp_byte;

    sbbt_ram u_block (
        .clk   (clk),
        .wr    (b_wr),
        .raddr (b_raddr),
        .rdata (b_rdata)
    );

    sbbt_ram u_scratch (
        .clk   (clk),
        .wr    (s_wr),
        .raddr (s_raddr),
        .rdata (s_rdata)
    );

    sbbt_alu u_alu (
        .op   (op_reg),
        .din  (b_rdata),
        .amp  (amp_reg),
        .odd  (k_reg),
        .dout (alu_out)
    );

    assign cfg_ready  = 1'b1;
    assign in_ready   = (state_reg == S_IDLE) && !out_valid_reg;
    assign in_fire    = in_valid && in_ready;
    assign out_valid  = out_valid_reg;
    assign read_value = rv_reg;
    assign status     = st_reg;

    assign n_eff   = (blen_reg > LEN_W'(MAX_LEN)) ? LEN_W'(MAX_LEN) : blen_reg;
    assign in_rng  = {1'b0, index} < n_eff;
    assign kind    = amp_reg[3:0];
    assign il_s    = 7'd2 << kind[2:0];
    assign il_w    = n_reg >> (kind[2:0] + 3'd1);
    assign ps      = n_reg >> 3;
    assign half    = n_reg >> 1;
    assign ptr_p1  = ptr_reg + LEN_W'(1);
    assign ptr_m1  = ptr_reg - LEN_W'(1);
    assign ptr_str = ptr_reg + {{(LEN_W-7){1'b0}}, stride_reg};
    assign cnt_p1  = cnt_reg + LEN_W'(1);

    always_comb
    begin
        for (int t = 0; t < 8; t++)
        begin
            bp_byte[t] = gather_reg[t][sub_reg];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        rv_next        = rv_reg;
        st_next        = st_reg;
        op_next        = op_reg;
        amp_next       = amp_reg;
        stride_next    = stride_reg;
        n_next         = n_reg;
        ptr_next       = ptr_reg;
        cnt_next       = cnt_reg;
        base_next      = base_reg;
        q_next         = q_reg;
        dst_next       = dst_reg;
        sub_next       = sub_reg;
        k_next         = k_reg;
        hold_next      = hold_reg;
        hold2_next     = hold2_reg;
        gather_next    = gather_reg;
        b_wr           = '0;
        s_wr           = '0;
        b_raddr        = ptr_reg[ADDR_W-1:0];
        s_raddr        = ptr_reg[ADDR_W-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                b_raddr = index;
                if (in_fire)
                begin
                    rv_next = 8'd0;
                    st_next = in_rng ? ST_OK : ST_RANGE;
                    unique case (cmd)
                        CMD_LOAD:
                        begin
                            b_wr           = '{we: in_rng, addr: index, data: value};
                            out_valid_next = 1'b1;
                        end
                        CMD_READ:
                        begin
                            if (in_rng)
                            begin
                                state_next = S_RD;
                            end
                            else
                            begin
                                out_valid_next = 1'b1;
                            end
                        end
                        CMD_APPLY:
                        begin
                            st_next     = ST_OK;
                            op_next     = op_type;
                            amp_next    = operand_amp;
                            stride_next = step_stride;
                            n_next      = n_eff;
                            ptr_next    = {{(LEN_W-6){1'b0}}, start_phase};
                            state_next  = S_START;
                        end
                        default:
                        begin
                            st_next        = ST_OK;
                            out_valid_next = 1'b1;
                        end
                    endcase
                end
            end
            S_RD:
            begin
                rv_next        = b_rdata;
                out_valid_next = 1'b1;
                state_next     = S_IDLE;
            end
            S_START:
            begin
                cnt_next   = '0;
                q_next     = '0;
                base_next  = '0;
                sub_next   = '0;
                k_next     = 1'b0;
                state_next = S_IDLE;
                if (op_reg == OP_SCRAMBLE)
                begin
                    ptr_next = '0;
                    priority if (kind <= KIND_IL_MAX)
                    begin
                        if ((n_reg[6:0] & (il_s - 7'd1)) != 7'd0)
                        begin
                            st_next = ST_REFUSE;
                        end
                        else if (n_reg != '0)
                        begin
                            state_next = S_IL_RD;
                        end
                    end
                    else if (kind == KIND_BITS)
                    begin
                        if (n_reg[2:0] != 3'd0)
                        begin
                            st_next = ST_REFUSE;
                        end
                        else if (n_reg != '0)
                        begin
                            state_next = S_BP_RD;
                        end
                    end
                    else if (kind == KIND_REV)
                    begin
                        if (n_reg != '0)
                        begin
                            state_next = S_RV_RD;
                        end
                    end
                    else
                    begin
                        if (n_reg[0])
                        begin
                            st_next = ST_REFUSE;
                        end
                        else if (n_reg != '0)
                        begin
                            state_next = (kind == KIND_NIBBLE) ? S_NP_RD0 : S_FD_RD0;
                        end
                    end
                end
                else if (stride_reg != 7'd0)
                begin
                    if (op_reg == OP_DELTA)
                    begin
                        ptr_next = n_reg;
                        if (n_reg > {{(LEN_W-7){1'b0}}, stride_reg})
                        begin
                            state_next = S_DX_RD0;
                        end
                    end
                    else if (ptr_reg < n_reg)
                    begin
                        state_next = S_ST_RD;
                    end
                end
                if (state_next == S_IDLE)
                begin
                    out_valid_next = 1'b1;
                end
            end
            S_ST_RD:
            begin
                state_next = S_ST_WR;
            end
            S_ST_WR:
            begin
                b_wr     = '{we: 1'b1, addr: ptr_reg[ADDR_W-1:0], data: alu_out};
                ptr_next = ptr_str;
                k_next   = !k_reg;
                if (ptr_str >= n_reg)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
                else
                begin
                    state_next = S_ST_RD;
                end
            end
            S_DX_RD0:
            begin
                b_raddr    = ptr_m1[ADDR_W-1:0];
                state_next = S_DX_RD1;
            end
            S_DX_RD1:
            begin
                b_raddr    = ADDR_W'(ptr_m1 - {{(LEN_W-7){1'b0}}, stride_reg});
                hold_next  = b_rdata;
                state_next = S_DX_WR;
            end
            S_DX_WR:
            begin
                b_wr     = '{we: 1'b1, addr: ptr_m1[ADDR_W-1:0], data: hold_reg ^ b_rdata};
                ptr_next = ptr_m1;
                if (ptr_m1 > {{(LEN_W-7){1'b0}}, stride_reg})
                begin
                    state_next = S_DX_RD0;
                end
                else
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_IL_RD:
            begin
                state_next = S_IL_WR;
            end
            S_IL_WR:
            begin
                s_wr     = '{we: 1'b1, addr: cnt_reg[ADDR_W-1:0], data: b_rdata};
                cnt_next = cnt_p1;
                if (q_reg + LEN_W'(1) == il_w)
                begin
                    q_next    = '0;
                    base_next = base_reg + LEN_W'(1);
                    ptr_next  = base_reg + LEN_W'(1);
                end
                else
                begin
                    q_next   = q_reg + LEN_W'(1);
                    ptr_next = ptr_reg + {{(LEN_W-7){1'b0}}, il_s};
                end
                if (cnt_p1 == n_reg)
                begin
                    ptr_next   = '0;
                    state_next = S_CP_RD;
                end
                else
                begin
                    state_next = S_IL_RD;
                end
            end
            S_BP_RD:
            begin
                state_next = S_BP_CAP;
            end
            S_BP_CAP:
            begin
                gather_next[sub_reg] = b_rdata;
                ptr_next             = ptr_p1;
                sub_next             = sub_reg + 3'd1;
                if (sub_reg == 3'd7)
                begin
                    dst_next   = base_reg;
                    state_next = S_BP_WR;
                end
                else
                begin
                    state_next = S_BP_RD;
                end
            end
            S_BP_WR:
            begin
                s_wr     = '{we: 1'b1, addr: dst_reg[ADDR_W-1:0], data: bp_byte};
                dst_next = dst_reg + ps;
                sub_next = sub_reg + 3'd1;
                if (sub_reg == 3'd7)
                begin
                    base_next = base_reg + LEN_W'(1);
                    if (ptr_reg >= n_reg)
                    begin
                        ptr_next   = '0;
                        state_next = S_CP_RD;
                    end
                    else
                    begin
                        state_next = S_BP_RD;
                    end
                end
            end
            S_NP_RD0:
            begin
                b_raddr    = {ptr_reg[ADDR_W-2:0], 1'b0};
                state_next = S_NP_RD1;
            end
            S_NP_RD1:
            begin
                b_raddr    = {ptr_reg[ADDR_W-2:0], 1'b1};
                hold_next  = b_rdata;
                state_next = S_NP_WR0;
            end
            S_NP_WR0:
            begin
                s_wr = '{we: 1'b1, addr: ptr_reg[ADDR_W-1:0],
                         data: {b_rdata[3:0], hold_reg[3:0]}};
                hold2_next = b_rdata;
                state_next = S_NP_WR1;
            end
            S_NP_WR1:
            begin
                s_wr = '{we: 1'b1, addr: ADDR_W'(ptr_reg + half),
                         data: {hold2_reg[7:4], hold_reg[7:4]}};
                ptr_next = ptr_p1;
                if (ptr_p1 == half)
                begin
                    ptr_next   = '0;
                    state_next = S_CP_RD;
                end
                else
                begin
                    state_next = S_NP_RD0;
                end
            end
            S_RV_RD:
            begin
                b_raddr    = ADDR_W'(n_reg - ptr_p1);
                state_next = S_RV_WR;
            end
            S_RV_WR:
            begin
                s_wr     = '{we: 1'b1, addr: ptr_reg[ADDR_W-1:0], data: b_rdata};
                ptr_next = ptr_p1;
                if (ptr_p1 == n_reg)
                begin
                    ptr_next   = '0;
                    state_next = S_CP_RD;
                end
                else
                begin
                    state_next = S_RV_RD;
                end
            end
            S_FD_RD0:
            begin
                state_next = S_FD_RD1;
            end
            S_FD_RD1:
            begin
                b_raddr    = ADDR_W'(ptr_reg + half);
                hold_next  = b_rdata;
                state_next = S_FD_WR0;
            end
            S_FD_WR0:
            begin
                s_wr = '{we: 1'b1, addr: ptr_reg[ADDR_W-1:0], data: hold_reg ^ b_rdata};
                hold2_next = b_rdata;
                state_next = S_FD_WR1;
            end
            S_FD_WR1:
            begin
                s_wr     = '{we: 1'b1, addr: ADDR_W'(ptr_reg + half), data: hold2_reg};
                ptr_next = ptr_p1;
                if (ptr_p1 == half)
                begin
                    ptr_next   = '0;
                    state_next = S_CP_RD;
                end
                else
                begin
                    state_next = S_FD_RD0;
                end
            end
            S_CP_RD:
            begin
                state_next = S_CP_WR;
            end
            S_CP_WR:
            begin
                b_wr     = '{we: 1'b1, addr: ptr_reg[ADDR_W-1:0], data: s_rdata};
                ptr_next = ptr_p1;
                if (ptr_p1 == n_reg)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
                else
                begin
                    state_next = S_CP_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            blen_reg      <= LEN_W'(MAX_LEN);
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                blen_reg <= block_len;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rv_reg     <= rv_next;
        st_reg     <= st_next;
        op_reg     <= op_next;
        amp_reg    <= amp_next;
        stride_reg <= stride_next;
        n_reg      <= n_next;
        ptr_reg    <= ptr_next;
        cnt_reg    <= cnt_next;
        base_reg   <= base_next;
        q_reg      <= q_next;
        dst_reg    <= dst_next;
        sub_reg    <= sub_next;
        k_reg      <= k_next;
        hold_reg   <= hold_next;
        hold2_reg  <= hold2_next;
        gather_reg <= gather_next;
    end

endmodule
